>>> rtl/urs_pkg.sv
// Shared constants, types and register codes for the ultrasonic range to servo PWM block.
package urs_pkg;

    localparam int ECHO_COUNT_BITS = 16;
    localparam int PRE_LOW_US      = 2;

    localparam int TRIG_W   = 10;
    localparam int TIME_W   = 17;
    localparam int MM_W     = 12;
    localparam int PERIOD_W = 15;
    localparam int DIST_W   = 17;
    localparam int ANGLE_W  = 8;
    localparam int PULSE_W  = 12;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam int DIST_MUL   = 1715;
    localparam int DIST_DIV   = 10000;
    localparam int ANG_FULL   = 180;
    localparam int PULSE_SPAN = 2000;
    localparam int PULSE_MIN  = 500;
    localparam int PULSE_MAX  = 2500;
    localparam int PULSE_INIT = 1500;
    localparam int ANGLE_INIT = 90;

    localparam int TRIG_HIGH_RST  = 12;
    localparam int ECHO_TMO_RST   = 80000;
    localparam int FRAME_GAP_RST  = 70000;
    localparam int DIST_MIN_RST   = 50;
    localparam int DIST_MAX_RST   = 300;
    localparam int PWM_PERIOD_RST = 20000;

    // Shared divider sizing: the widest dividend is the echo width times the distance scale.
    localparam int DIV_W = ECHO_COUNT_BITS + $clog2(DIST_MUL);
    localparam int DVS_W = $clog2(DIST_DIV + 1);
    localparam int CNT_W = $clog2(DIV_W + 1);

    typedef enum logic [2:0] {
        REG_TRIG_HIGH,
        REG_ECHO_TIMEOUT,
        REG_FRAME_GAP,
        REG_DIST_MIN,
        REG_DIST_MAX,
        REG_PWM_PERIOD
    } reg_idx_t;

    typedef struct packed {
        logic [TRIG_W-1:0]   trigger_high_us;
        logic [TIME_W-1:0]   echo_timeout_us;
        logic [TIME_W-1:0]   frame_gap_us;
        logic [MM_W-1:0]     dist_min_mm;
        logic [MM_W-1:0]     dist_max_mm;
        logic [PERIOD_W-1:0] pwm_period_us;
    } cfg_t;

endpackage

>>> rtl/urs_cfg.sv
// Configuration register file with an APB-style write and read port.
module urs_cfg
    import urs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_TRIG_HIGH:    cfg_next.trigger_high_us = pwdata[TRIG_W-1:0];
                REG_ECHO_TIMEOUT: cfg_next.echo_timeout_us = pwdata[TIME_W-1:0];
                REG_FRAME_GAP:    cfg_next.frame_gap_us    = pwdata[TIME_W-1:0];
                REG_DIST_MIN:     cfg_next.dist_min_mm     = pwdata[MM_W-1:0];
                REG_DIST_MAX:     cfg_next.dist_max_mm     = pwdata[MM_W-1:0];
                REG_PWM_PERIOD:   cfg_next.pwm_period_us   = pwdata[PERIOD_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_TRIG_HIGH:    prdata = PDATA_W'(cfg_reg.trigger_high_us);
            REG_ECHO_TIMEOUT: prdata = PDATA_W'(cfg_reg.echo_timeout_us);
            REG_FRAME_GAP:    prdata = PDATA_W'(cfg_reg.frame_gap_us);
            REG_DIST_MIN:     prdata = PDATA_W'(cfg_reg.dist_min_mm);
            REG_DIST_MAX:     prdata = PDATA_W'(cfg_reg.dist_max_mm);
            REG_PWM_PERIOD:   prdata = PDATA_W'(cfg_reg.pwm_period_us);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_high_us <= TRIG_W'(TRIG_HIGH_RST);
            cfg_reg.echo_timeout_us <= TIME_W'(ECHO_TMO_RST);
            cfg_reg.frame_gap_us    <= TIME_W'(FRAME_GAP_RST);
            cfg_reg.dist_min_mm     <= MM_W'(DIST_MIN_RST);
            cfg_reg.dist_max_mm     <= MM_W'(DIST_MAX_RST);
            cfg_reg.pwm_period_us   <= PERIOD_W'(PWM_PERIOD_RST);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/urs_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
module urs_div
    import urs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] dvs_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             run_reg;
    logic             run_next;
    logic             done_reg;
    logic             done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(DIV_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

>>> rtl/ultrasonic_range_to_servo_pwm.sv
// Ultrasonic ranging frame controller with echo timing, distance to angle mapping and servo PWM.
// Each input word is one 1 us tick with the sampled echo level, and each tick yields one output
// word with the trigger and servo levels and the latest measurement. A tick that does not end a
// valid measurement needs no division, so such ticks can arrive on every clock unless the output
// is stalled. A tick that ends a valid measurement runs three divisions (distance, angle, pulse
// width) one after another on a single 27-step restoring divider, and input is held off until the
// last of them is done. If the configured maximum distance is not above the minimum, the angle
// division and the pulse division are skipped.
module ultrasonic_range_to_servo_pwm
    import urs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       echo_level,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       trig_level,
    output logic                       servo_level,
    output logic                       frame_done,
    output logic                       timed_out,
    output logic [ECHO_COUNT_BITS-1:0] echo_us,
    output logic [DIST_W-1:0]          range_mm,
    output logic [ANGLE_W-1:0]         angle_deg,
    output logic [PULSE_W-1:0]         pulse_us
);

    typedef enum logic [1:0] {PH_PRE, PH_TRIG, PH_WAIT, PH_GAP} phase_t;
    typedef enum logic [1:0] {SQ_IDLE, SQ_DIST, SQ_ANG, SQ_PULSE} seq_t;

    cfg_t cfg;

    phase_t                     phase_reg, phase_next;
    seq_t                       seq_reg, seq_next;
    logic [TIME_W-1:0]          ticks_reg, ticks_next;
    logic                       rise_reg, rise_next;
    logic                       prev_reg, prev_next;
    logic                       meas_reg, meas_next;
    logic [ECHO_COUNT_BITS-1:0] count_reg, count_next;
    logic [ECHO_COUNT_BITS-1:0] last_echo_reg, last_echo_next;
    logic [PERIOD_W-1:0]        pwm_reg, pwm_next;
    logic [PULSE_W-1:0]         pact_reg, pact_next;
    logic [PULSE_W-1:0]         ppend_reg, ppend_next;
    logic [DIST_W-1:0]          dist_reg, dist_next;
    logic [ANGLE_W-1:0]         angle_reg, angle_next;
    logic                       ovalid_reg, ovalid_next;
    logic                       otrig_reg, otrig_next;
    logic                       oservo_reg, oservo_next;
    logic                       odone_reg, odone_next;
    logic                       otmo_reg, otmo_next;

    logic                       accept_in;
    logic [PERIOD_W:0]          pwm_inc;
    logic [PERIOD_W-1:0]        period_min1;
    logic [TIME_W:0]            ticks_inc;
    logic [TIME_W-1:0]          trig_lim;
    logic [TIME_W-1:0]          tmo_lim;
    logic [TIME_W-1:0]          gap_lim;
    logic                       need_calc;
    logic [DIST_W-1:0]          dist_sat;
    logic [DIST_W-1:0]          dist_lo;
    logic [DIST_W-1:0]          dist_clamp;
    logic                       span_ok;
    logic [ANGLE_W-1:0]         angle_q;

    logic                       div_start;
    logic [DIV_W-1:0]           div_dividend;
    logic [DVS_W-1:0]           div_divisor;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quo;

    urs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    urs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_stall    = (seq_reg != SQ_IDLE) || (ovalid_reg && out_stall);
    assign accept_in   = in_valid && !in_stall;
    assign out_valid   = ovalid_reg;
    assign trig_level  = otrig_reg;
    assign servo_level = oservo_reg;
    assign frame_done  = odone_reg;
    assign timed_out   = otmo_reg;
    assign echo_us     = last_echo_reg;
    assign range_mm    = dist_reg;
    assign angle_deg   = angle_reg;
    assign pulse_us    = pact_reg;

    assign pwm_inc     = {1'b0, pwm_reg} + (PERIOD_W + 1)'(1);
    assign period_min1 = (cfg.pwm_period_us == '0) ? PERIOD_W'(1) : cfg.pwm_period_us;
    assign ticks_inc   = {1'b0, ticks_reg} + (TIME_W + 1)'(1);
    assign trig_lim    = (cfg.trigger_high_us == '0) ? TIME_W'(1) : TIME_W'(cfg.trigger_high_us);
    assign tmo_lim     = (cfg.echo_timeout_us == '0) ? TIME_W'(1) : cfg.echo_timeout_us;
    assign gap_lim     = (cfg.frame_gap_us == '0) ? TIME_W'(1) : cfg.frame_gap_us;

    // Distance clamp feeding the angle division; the distance comes straight off the divider.
    assign dist_sat   = (div_quo > DIV_W'((1 << DIST_W) - 1)) ? '1 : div_quo[DIST_W-1:0];
    assign dist_lo    = (dist_sat < DIST_W'(cfg.dist_min_mm)) ?
                        DIST_W'(cfg.dist_min_mm) : dist_sat;
    assign dist_clamp = (dist_lo > DIST_W'(cfg.dist_max_mm)) ? DIST_W'(cfg.dist_max_mm) : dist_lo;
    assign span_ok    = cfg.dist_max_mm > cfg.dist_min_mm;
    assign angle_q    = (div_quo > DIV_W'(ANG_FULL)) ? ANGLE_W'(ANG_FULL) : div_quo[ANGLE_W-1:0];

    always_comb
    begin
        phase_next     = phase_reg;
        seq_next       = seq_reg;
        ticks_next     = ticks_reg;
        rise_next      = rise_reg;
        prev_next      = prev_reg;
        meas_next      = meas_reg;
        count_next     = count_reg;
        last_echo_next = last_echo_reg;
        pwm_next       = pwm_reg;
        pact_next      = pact_reg;
        ppend_next     = ppend_reg;
        dist_next      = dist_reg;
        angle_next     = angle_reg;
        ovalid_next    = ovalid_reg;
        otrig_next     = otrig_reg;
        oservo_next    = oservo_reg;
        odone_next     = odone_reg;
        otmo_next      = otmo_reg;
        need_calc      = 1'b0;
        div_start      = 1'b0;
        div_dividend   = DIV_W'(last_echo_reg) * DIV_W'(DIST_MUL);
        div_divisor    = DVS_W'(DIST_DIV);

        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        if (accept_in)
        begin
            // The new pulse width is loaded only at the start of a PWM period.
            if (pwm_reg == '0)
            begin
                pact_next = ppend_reg;
            end
            oservo_next = PERIOD_W'(pact_next) > pwm_reg;
            pwm_next    = (pwm_inc >= {1'b0, period_min1}) ? '0 : pwm_inc[PERIOD_W-1:0];

            if ((phase_reg != PH_GAP) && !meas_reg)
            begin
                if (!rise_reg)
                begin
                    if (echo_level && !prev_reg)
                    begin
                        rise_next  = 1'b1;
                        count_next = '0;
                    end
                end
                else
                begin
                    count_next = count_reg + ECHO_COUNT_BITS'(1);
                    if (!echo_level && prev_reg)
                    begin
                        last_echo_next = count_next;
                        meas_next      = 1'b1;
                        rise_next      = 1'b0;
                    end
                end
            end
            prev_next = echo_level;

            otrig_next = 1'b0;
            odone_next = 1'b0;
            otmo_next  = 1'b0;
            unique case (phase_reg)
                PH_PRE:
                begin
                    ticks_next = ticks_inc[TIME_W-1:0];
                    if (ticks_inc >= (TIME_W + 1)'(PRE_LOW_US))
                    begin
                        phase_next = PH_TRIG;
                        ticks_next = '0;
                    end
                end
                PH_TRIG:
                begin
                    otrig_next = 1'b1;
                    ticks_next = ticks_inc[TIME_W-1:0];
                    if (ticks_inc >= {1'b0, trig_lim})
                    begin
                        phase_next = PH_WAIT;
                        ticks_next = '0;
                    end
                end
                PH_WAIT:
                begin
                    if (meas_next)
                    begin
                        need_calc  = 1'b1;
                        odone_next = 1'b1;
                        phase_next = PH_GAP;
                        ticks_next = '0;
                    end
                    else
                    begin
                        ticks_next = ticks_inc[TIME_W-1:0];
                        if (ticks_inc >= {1'b0, tmo_lim})
                        begin
                            odone_next = 1'b1;
                            otmo_next  = 1'b1;
                            phase_next = PH_GAP;
                            ticks_next = '0;
                        end
                    end
                end
                PH_GAP:
                begin
                    ticks_next = ticks_inc[TIME_W-1:0];
                    if (ticks_inc >= {1'b0, gap_lim})
                    begin
                        phase_next = PH_PRE;
                        ticks_next = '0;
                        rise_next  = 1'b0;
                        meas_next  = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = PH_PRE;
                end
            endcase

            ovalid_next = !need_calc;
        end

        unique case (seq_reg)
            SQ_IDLE:
            begin
                if (need_calc)
                begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(last_echo_next) * DIV_W'(DIST_MUL);
                    div_divisor  = DVS_W'(DIST_DIV);
                    seq_next     = SQ_DIST;
                end
            end
            SQ_DIST:
            begin
                if (div_done)
                begin
                    dist_next = dist_sat;
                    if (span_ok)
                    begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(dist_clamp[MM_W-1:0] - cfg.dist_min_mm) *
                                       DIV_W'(ANG_FULL);
                        div_divisor  = DVS_W'(cfg.dist_max_mm - cfg.dist_min_mm);
                        seq_next     = SQ_ANG;
                    end
                    else
                    begin
                        angle_next  = '0;
                        ppend_next  = PULSE_W'(PULSE_MIN);
                        ovalid_next = 1'b1;
                        seq_next    = SQ_IDLE;
                    end
                end
            end
            SQ_ANG:
            begin
                if (div_done)
                begin
                    angle_next   = angle_q;
                    div_start    = 1'b1;
                    div_dividend = DIV_W'(angle_q) * DIV_W'(PULSE_SPAN);
                    div_divisor  = DVS_W'(ANG_FULL);
                    seq_next     = SQ_PULSE;
                end
            end
            SQ_PULSE:
            begin
                if (div_done)
                begin
                    if (div_quo > DIV_W'(PULSE_MAX - PULSE_MIN))
                    begin
                        ppend_next = PULSE_W'(PULSE_MAX);
                    end
                    else
                    begin
                        ppend_next = PULSE_W'(PULSE_MIN) + div_quo[PULSE_W-1:0];
                    end
                    ovalid_next = 1'b1;
                    seq_next    = SQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PRE;
            seq_reg       <= SQ_IDLE;
            ticks_reg     <= '0;
            rise_reg      <= 1'b0;
            prev_reg      <= 1'b0;
            meas_reg      <= 1'b0;
            count_reg     <= '0;
            last_echo_reg <= '0;
            pwm_reg       <= '0;
            pact_reg      <= PULSE_W'(PULSE_INIT);
            ppend_reg     <= PULSE_W'(PULSE_INIT);
            dist_reg      <= '0;
            angle_reg     <= ANGLE_W'(ANGLE_INIT);
            ovalid_reg    <= 1'b0;
            otrig_reg     <= 1'b0;
            oservo_reg    <= 1'b0;
            odone_reg     <= 1'b0;
            otmo_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            seq_reg       <= seq_next;
            ticks_reg     <= ticks_next;
            rise_reg      <= rise_next;
            prev_reg      <= prev_next;
            meas_reg      <= meas_next;
            count_reg     <= count_next;
            last_echo_reg <= last_echo_next;
            pwm_reg       <= pwm_next;
            pact_reg      <= pact_next;
            ppend_reg     <= ppend_next;
            dist_reg      <= dist_next;
            angle_reg     <= angle_next;
            ovalid_reg    <= ovalid_next;
            otrig_reg     <= otrig_next;
            oservo_reg    <= oservo_next;
            odone_reg     <= odone_next;
            otmo_reg      <= otmo_next;
        end
    end

endmodule

>>> rtl/urs_chk.sv
// Port-level assertion checker for the ultrasonic range to servo PWM block, with its bind.
module urs_chk
    import urs_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       trig_level,
    input logic                       servo_level,
    input logic                       frame_done,
    input logic                       timed_out,
    input logic [ANGLE_W-1:0]         angle_deg,
    input logic [PULSE_W-1:0]         pulse_us
);

    // A timeout is only ever reported on the word that ends the frame.
    a_tmo_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> frame_done)
        else $error("timed_out without frame_done");

    // The trigger is never driven during the word that closes the echo wait.
    a_no_trig_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !trig_level)
        else $error("trigger high on a frame_done word");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pulse_us >= PULSE_W'(PULSE_MIN)) && (pulse_us <= PULSE_W'(PULSE_MAX)))
        else $error("pulse width outside servo range");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle_deg <= ANGLE_W'(ANG_FULL))
        else $error("angle above full scale");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(servo_level) && $stable(frame_done))
        else $error("stalled output word changed");

endmodule

bind ultrasonic_range_to_servo_pwm urs_chk u_urs_chk (.*);
